>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int MAX_RUN    = 64;

    localparam int BLK_W  = $clog2(MAX_BLOCKS);      // block index
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);  // block count
    localparam int RUN_W  = $clog2(MAX_RUN + 1);     // run length / grant count
    localparam int WORD_W = 64;                      // bitmap row width
    localparam int WBIT_W = $clog2(WORD_W);
    localparam int ROWS   = MAX_BLOCKS / WORD_W;
    localparam int ROW_W  = BLK_W - WBIT_W;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [1:0] ST_RANGE        = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } bm_rd_t;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } bm_wr_t;

endpackage

>>> rtl/bba_ifs.sv
`timescale 1ns / 1ps

interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [RUN_W-1:0] run_length;
    logic [BLK_W-1:0] block_number;

    modport source (output valid, command, run_length, block_number, input ready);
    modport sink   (input valid, command, run_length, block_number, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] granted_block;
    logic [1:0]       status;
    logic             last;
    logic [CNT_W-1:0] free_left;

    modport source (output valid, granted_block, status, last, free_left, input ready);
    modport sink   (input valid, granted_block, status, last, free_left, output ready);
endinterface

>>> rtl/bba_cell.sv
`timescale 1ns / 1ps

// One stage of the grant chain: holds a block index, takes its neighbor's on shift.
module bba_cell import bba_pkg::*; (
    input  logic             clk,
    input  logic             shift_en,
    input  logic [BLK_W-1:0] d,
    output logic [BLK_W-1:0] q
);

    logic [BLK_W-1:0] blk_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            blk_reg <= d;
        end
    end

    assign q = blk_reg;

endmodule

>>> rtl/bba_bitmap.sv
`timescale 1ns / 1ps

// Used-block bitmap, one row of WORD_W bits per address.
// Rows never written read as all free (row valid bits, cleared by reset).
module bba_bitmap import bba_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  bm_rd_t            rd,
    input  bm_wr_t            wr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr.en)
        begin
            row_valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= row_valid_reg[rd.addr] ? mem[rd.addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// req       in   valid/ready        command, run_length, block_number
// rsp       out  valid/ready        granted_block, status, last, free_left
// cfg       in   cfg_wr_en          cfg_wr_data = total_blocks
//
// One item at a time. Free: one bitmap read-modify-write, then the output wait.
// Allocate: scan the bitmap rows for free blocks, shift the grant chain until
// the first grant reaches cell 0, then one bitmap read-modify-write per grant
// on the row memory, each followed by its result.
// Reset: asynchronous, all blocks free, no clearing pass (row valid bits).
// A stalled rsp holds the output register; the FSM waits in EMIT behind it.

module bitmap_block_allocator import bba_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    bba_req_if.sink          req,
    bba_rsp_if.source        rsp
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_FREE_CHK  = 8'b0000_0010,
        S_SCAN_LOAD = 8'b0000_0100,
        S_SCAN_PICK = 8'b0000_1000,
        S_ALIGN     = 8'b0001_0000,
        S_COMMIT_RD = 8'b0010_0000,
        S_COMMIT_WR = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [RUN_W-1:0]  n_reg, n_next;              // grants found, then grants left
    logic [RUN_W-1:0]  shift_cnt_reg, shift_cnt_next;
    logic [ROW_W-1:0]  scan_w_reg, scan_w_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [RUN_W-1:0]  req_reg, req_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [WORD_W-1:0] cur_reg, cur_next;          // free, in-range bits of current row
    logic [BLK_W-1:0]  pend_grant_reg, pend_grant_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic              pend_last_reg, pend_last_next;
    logic [BLK_W-1:0]  out_grant_reg;
    logic [1:0]        out_status_reg;
    logic              out_last_reg;
    logic [CNT_W-1:0]  out_free_left_reg;

    logic              emit;
    logic              out_free;
    bm_rd_t            bm_rd;
    bm_wr_t            bm_wr;
    logic [WORD_W-1:0] rd_data;

    // grant chain
    logic              chain_shift;
    logic [BLK_W-1:0]  chain_in;
    logic [BLK_W-1:0]  cell_q [MAX_RUN];
    logic [BLK_W-1:0]  head;

    logic [WORD_W-1:0] range_mask;
    logic [WBIT_W-1:0] pick_idx;
    logic [ROW_W:0]    scan_w_inc;
    logic              scan_end;
    logic [CNT_W-1:0]  cfg_total;

    bba_bitmap u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (bm_rd),
        .wr      (bm_wr),
        .rd_data (rd_data)
    );

    // Grants enter at the top cell and move toward cell 0, which feeds the commit.
    for (genvar k = 0; k < MAX_RUN; k++)
    begin : g_chain
        logic [BLK_W-1:0] d_in;
        if (k == MAX_RUN - 1)
        begin : g_top
            assign d_in = chain_in;
        end
        else
        begin : g_mid
            assign d_in = cell_q[k + 1];
        end
        bba_cell u_cell (
            .clk      (clk),
            .shift_en (chain_shift),
            .d        (d_in),
            .q        (cell_q[k])
        );
    end

    assign head = cell_q[0];

    // bits of row scan_w_reg that lie below total_blocks
    always_comb
    begin
        logic full_row;
        logic part_row;
        full_row = {1'b0, scan_w_reg} < total_reg[CNT_W-1:WBIT_W];
        part_row = {1'b0, scan_w_reg} == total_reg[CNT_W-1:WBIT_W];
        for (int i = 0; i < WORD_W; i++)
        begin
            range_mask[i] = full_row
                          || (part_row && (WBIT_W'(i) < total_reg[WBIT_W-1:0]));
        end
    end

    // lowest free bit of the current row
    always_comb
    begin
        pick_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cur_reg[i])
            begin
                pick_idx = WBIT_W'(i);
            end
        end
    end

    assign scan_w_inc = {1'b0, scan_w_reg} + 1'b1;
    assign scan_end   = {scan_w_inc, {WBIT_W{1'b0}}} >= total_reg;
    assign cfg_total  = (cfg_wr_data > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_wr_data;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        total_next       = total_reg;
        free_cnt_next    = free_cnt_reg;
        n_next           = n_reg;
        shift_cnt_next   = shift_cnt_reg;
        scan_w_next      = scan_w_reg;
        req_next         = req_reg;
        blk_next         = blk_reg;
        cur_next         = cur_reg;
        pend_grant_next  = pend_grant_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        emit             = 1'b0;
        chain_shift      = 1'b0;
        chain_in         = '0;
        bm_rd            = '0;
        bm_wr            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next        = req.run_length;
                    blk_next        = req.block_number;
                    pend_grant_next = '0;
                    pend_last_next  = 1'b1;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.run_length == '0 || req.run_length > RUN_W'(MAX_RUN))
                        begin
                            pend_status_next = ST_RANGE;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            scan_w_next    = '0;
                            n_next         = '0;
                            shift_cnt_next = '0;
                            bm_rd.en       = 1'b1;
                            bm_rd.addr     = '0;
                            state_next     = S_SCAN_LOAD;
                        end
                    end
                    else if (req.block_number == '0)
                    begin
                        // null block: ignored
                        pend_status_next = ST_OK;
                        state_next       = S_EMIT;
                    end
                    else if ({1'b0, req.block_number} >= total_reg)
                    begin
                        pend_status_next = ST_RANGE;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        bm_rd.en   = 1'b1;
                        bm_rd.addr = req.block_number[BLK_W-1:WBIT_W];
                        state_next = S_FREE_CHK;
                    end
                end
            end

            S_FREE_CHK:
            begin
                if (!rd_data[blk_reg[WBIT_W-1:0]])
                begin
                    pend_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    bm_wr.en   = 1'b1;
                    bm_wr.addr = blk_reg[BLK_W-1:WBIT_W];
                    bm_wr.data = rd_data & ~(WORD_W'(1) << blk_reg[WBIT_W-1:0]);
                    if (free_cnt_reg < total_reg)
                    begin
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    pend_status_next = ST_OK;
                end
                state_next = S_EMIT;
            end

            S_SCAN_LOAD:
            begin
                cur_next   = ~rd_data & range_mask;
                state_next = S_SCAN_PICK;
            end

            S_SCAN_PICK:
            begin
                if (cur_reg != '0)
                begin
                    chain_shift    = 1'b1;
                    chain_in       = {scan_w_reg, pick_idx};
                    cur_next       = cur_reg & ~(WORD_W'(1) << pick_idx);
                    n_next         = n_reg + 1'b1;
                    shift_cnt_next = shift_cnt_reg + 1'b1;
                    if (RUN_W'(n_reg + 1'b1) == req_reg)
                    begin
                        state_next = S_ALIGN;
                    end
                end
                else if (scan_end)
                begin
                    // short allocation: nothing was marked, report and drop
                    pend_status_next = ST_NO_SPACE;
                    state_next       = S_EMIT;
                end
                else
                begin
                    scan_w_next = scan_w_inc[ROW_W-1:0];
                    bm_rd.en    = 1'b1;
                    bm_rd.addr  = scan_w_inc[ROW_W-1:0];
                    state_next  = S_SCAN_LOAD;
                end
            end

            S_ALIGN:
            begin
                // walk the first grant down to cell 0
                if (shift_cnt_reg == RUN_W'(MAX_RUN))
                begin
                    state_next = S_COMMIT_RD;
                end
                else
                begin
                    chain_shift    = 1'b1;
                    shift_cnt_next = shift_cnt_reg + 1'b1;
                end
            end

            S_COMMIT_RD:
            begin
                bm_rd.en   = 1'b1;
                bm_rd.addr = head[BLK_W-1:WBIT_W];
                state_next = S_COMMIT_WR;
            end

            S_COMMIT_WR:
            begin
                bm_wr.en   = 1'b1;
                bm_wr.addr = head[BLK_W-1:WBIT_W];
                bm_wr.data = rd_data | (WORD_W'(1) << head[WBIT_W-1:0]);
                if (free_cnt_reg != '0)
                begin
                    free_cnt_next = free_cnt_reg - 1'b1;
                end
                pend_grant_next  = head;
                pend_status_next = ST_OK;
                pend_last_next   = (n_reg == RUN_W'(1));
                n_next           = n_reg - 1'b1;
                state_next       = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chain_shift = 1'b1;
                        state_next  = S_COMMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the user must write the register only while idle; the block does not enforce it
        if (cfg_wr_en)
        begin
            total_next    = cfg_total;
            free_cnt_next = cfg_total;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= CNT_W'(MAX_BLOCKS);
            free_cnt_reg  <= CNT_W'(MAX_BLOCKS);
            n_reg         <= '0;
            shift_cnt_reg <= '0;
            scan_w_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            free_cnt_reg  <= free_cnt_next;
            n_reg         <= n_next;
            shift_cnt_reg <= shift_cnt_next;
            scan_w_reg    <= scan_w_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        blk_reg         <= blk_next;
        cur_reg         <= cur_next;
        pend_grant_reg  <= pend_grant_next;
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
        if (emit)
        begin
            out_grant_reg     <= pend_grant_reg;
            out_status_reg    <= pend_status_reg;
            out_last_reg      <= pend_last_reg;
            out_free_left_reg <= free_cnt_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_block = out_grant_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.last          = out_last_reg;
    assign rsp.free_left     = out_free_left_reg;

`ifndef ASSERT_OFF
    a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= total_reg)
        else $error("free count above total_blocks");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.last)
        else $error("error result not flagged last");

    a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_PICK |-> n_reg < req_reg)
        else $error("scan found more blocks than requested");

    a_align_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALIGN |-> n_reg == req_reg)
        else $error("chain aligned with a partial grant set");

    a_commit_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT_WR |-> n_reg != '0)
        else $error("commit with no grant left");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bba_pkg::*;

    // Run length of the testbench, in clock cycles.
    // Slowest legal item: a full scan and chain alignment plus 64 grants, each
    // of them waiting out a sparse receiver; the limit stays well above that.
    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    // Quiet time after the last expected result: covers a full allocate scan.
    localparam int unsigned TAIL_CYCLES = 600;
    // Keep the log short when things go badly wrong.
    localparam int unsigned PRINT_LIMIT = 40;

    typedef struct {
        logic [BLK_W-1:0] block;
        logic [1:0]       status;
        logic             last;
        logic [CNT_W-1:0] free_left;
    } grant_report_t;

    // Receiver behavior, changed after a random hold time.
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    // Mirror of the allocator: bitmap, free counter and block count, plus the
    // reports that accepted requests still owe.
    class block_ledger_t;
        bit               used [MAX_BLOCKS];
        int unsigned      total      = MAX_BLOCKS;
        int unsigned      free_count = MAX_BLOCKS;
        grant_report_t    owed_reports[$];
        int unsigned      errors;
        int unsigned      requests;
        int unsigned      reports;
        int unsigned      status_seen [4];

        task flag_mismatch(input string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        function int unsigned outstanding();
            return owed_reports.size();
        endfunction

        // Write of total_blocks: clamps to the bitmap size, reloads the
        // counter, leaves the bitmap alone.
        function void set_total(input logic [CNT_W-1:0] value);
            total = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
            free_count = total;
        endfunction

        function void owe_report(input int unsigned blk, input logic [1:0] st,
                                 input logic fin);
            grant_report_t r;
            r.block     = blk[BLK_W-1:0];
            r.status    = st;
            r.last      = fin;
            r.free_left = free_count[CNT_W-1:0];
            owed_reports = {owed_reports, r};
        endfunction

        // Predicts the reports of one accepted request and updates the mirror.
        function void apply_request(input logic cmd, input logic [RUN_W-1:0] len,
                                    input logic [BLK_W-1:0] blk);
            int unsigned found[$];
            int unsigned want_n;
            want_n = len;
            requests++;
            if (cmd == CMD_ALLOC)
            begin
                if (want_n == 0 || want_n > MAX_RUN)
                begin
                    owe_report(0, ST_RANGE, 1'b1);
                    return;
                end
                // first fit: lowest free blocks below the block count
                for (int unsigned i = 0; i < total && found.size() < want_n; i++)
                    if (!used[i])
                        found = {found, i};
                if (found.size() < want_n)
                begin
                    owe_report(0, ST_NO_SPACE, 1'b1);
                    return;
                end
                foreach (found[k])
                begin
                    used[found[k]] = 1'b1;
                    if (free_count > 0)
                        free_count--;
                    owe_report(found[k], ST_OK, k == found.size() - 1);
                end
                return;
            end
            if (blk == 0)
                owe_report(0, ST_OK, 1'b1);             // null pointer, ignored
            else if (blk >= total)
                owe_report(0, ST_RANGE, 1'b1);
            else if (!used[blk])
                owe_report(0, ST_ALREADY_FREE, 1'b1);
            else
            begin
                used[blk] = 1'b0;
                if (free_count < total)
                    free_count++;
                owe_report(0, ST_OK, 1'b1);
            end
        endfunction

        // Random used block below the block count, 0 when there is none.
        function int unsigned pick_used_block();
            int unsigned start;
            int unsigned idx;
            start = $urandom_range(0, total - 1);
            for (int unsigned k = 0; k < total; k++)
            begin
                idx = (start + k) % total;
                if (used[idx])
                    return idx;
            end
            return 0;
        endfunction

        task check_result(input logic [BLK_W-1:0] blk, input logic [1:0] st,
                          input logic fin, input logic [CNT_W-1:0] left);
            grant_report_t want;
            reports++;
            if (!$isunknown(st))
                status_seen[st]++;
            if (owed_reports.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result: block %0d status %0d last %0d",
                                        blk, st, fin));
                return;
            end
            want = owed_reports.pop_front();
            if (blk !== want.block)
                flag_mismatch($sformatf("granted_block %0d, expected %0d", blk, want.block));
            if (st !== want.status)
                flag_mismatch($sformatf("status %0d, expected %0d (block %0d)",
                                        st, want.status, want.block));
            if (fin !== want.last)
                flag_mismatch($sformatf("last %0d, expected %0d (block %0d)",
                                        fin, want.last, want.block));
            if (left !== want.free_left)
                flag_mismatch($sformatf("free_left %0d, expected %0d (block %0d)",
                                        left, want.free_left, want.block));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    block_ledger_t ledger;

    int unsigned burst_left;    // items still to send back to back
    int unsigned settings;      // block-count writes done
    int unsigned cycle_count;
    rx_mode_t    rx_mode;
    int unsigned rx_hold;       // cycles until the receiver changes mode

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog. A hang anywhere (lost result, stuck ready) ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, ledger.outstanding());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: the receiver stalls on its own schedule, independent of
    // what the sender is doing. Modes: always ready, coin flip, a fixed
    // 3-of-7 stall pattern, and a sparse one that is rarely ready and so holds
    // the output register between results.
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_hold = $urandom_range(50, 400);
        end
        else
            rx_hold--;
        case (rx_mode)
            RX_STEADY:  rsp_ch.ready <= 1'b1;
            RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: rsp_ch.ready <= (cycle_count % 7) >= 3;
            default:    rsp_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Result monitor: values seen here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            ledger.check_result(rsp_ch.granted_block, rsp_ch.status,
                                rsp_ch.last, rsp_ch.free_left);
    end

    // Present one request and hold it until the block takes it. Requests go
    // out in bursts; a new burst may start after a random gap. The item is
    // noted in the ledger at the accepting edge, so the ledger is always up
    // to date before the next request is chosen.
    task automatic send_request(input logic cmd, input logic [RUN_W-1:0] len,
                                input logic [BLK_W-1:0] blk);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.run_length   <= len;
        req_ch.block_number <= blk;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        ledger.apply_request(cmd, len, blk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
    endtask

    // Block-count write, only with the block idle.
    task automatic write_total(input logic [CNT_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        ledger.set_total(value);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    initial
    begin
        logic [CNT_W-1:0] phase_total [6];
        int unsigned      phase_items [6];
        int unsigned      roll;
        int unsigned      pick;
        logic [RUN_W-1:0] len;

        // every input known from time zero
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_ALLOC;
        req_ch.run_length   = '0;
        req_ch.block_number = '0;
        rsp_ch.ready        = 1'b0;
        rx_mode             = RX_STEADY;
        rx_hold             = 0;
        burst_left          = 0;
        settings            = 0;
        cycle_count         = 0;
        ledger              = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed: reset block count of 4096 ----
        send_request(CMD_ALLOC, 1, 0);        // first grant is block zero
        send_request(CMD_ALLOC, 64, 0);       // longest run, blocks 1..64
        send_request(CMD_ALLOC, 0, 0);        // zero run length
        send_request(CMD_ALLOC, 65, 0);       // just over the longest run
        send_request(CMD_ALLOC, 127, 0);      // all-ones run length
        send_request(CMD_FREE, 0, 0);         // null pointer, ignored
        send_request(CMD_FREE, 0, 4095);      // top block, never used
        send_request(CMD_FREE, 0, 5);         // normal free
        send_request(CMD_FREE, 0, 5);         // same block again
        send_request(CMD_ALLOC, 3, 0);        // first fit fills the hole at 5
        send_request(CMD_FREE, 0, 64);
        send_request(CMD_ALLOC, 1, 0);

        // ---- directed: 70 blocks, most of them already taken ----
        write_total(70);
        send_request(CMD_FREE, 0, 10);        // counter already at the block count
        send_request(CMD_ALLOC, 64, 0);       // short allocation
        send_request(CMD_ALLOC, 3, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 70);        // first block past the end
        send_request(CMD_FREE, 0, 4095);
        send_request(CMD_FREE, 0, 69);
        send_request(CMD_FREE, 0, 2);

        // ---- directed: one block, and it is in use ----
        write_total(1);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 1);

        // ---- random phases over several block counts ----
        // 8191 is clamped to the bitmap size by the block.
        phase_total[0] = 13'd4096;  phase_items[0] = 85;
        phase_total[1] = 13'd64;    phase_items[1] = 85;
        phase_total[2] = 13'd8191;  phase_items[2] = 80;
        phase_total[3] = CNT_W'($urandom_range(2, 200));
        phase_items[3] = 85;
        phase_total[4] = 13'd1;     phase_items[4] = 20;
        phase_total[5] = CNT_W'($urandom_range(65, 4096));
        phase_items[5] = 85;

        foreach (phase_total[p])
        begin
            write_total(phase_total[p]);
            repeat (phase_items[p])
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    // allocate: mostly short runs, some long, a few illegal
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        len = RUN_W'($urandom_range(1, 8));
                    else if (pick < 9)
                        len = RUN_W'($urandom_range(9, MAX_RUN));
                    else if ($urandom_range(0, 2) == 0)
                        len = '0;
                    else
                        len = RUN_W'($urandom_range(MAX_RUN + 1, 127));
                    send_request(CMD_ALLOC, len, BLK_W'($urandom));
                end
                else if (roll < 80)
                    // give back something that is really held
                    send_request(CMD_FREE, RUN_W'($urandom),
                                 BLK_W'(ledger.pick_used_block()));
                else if (roll < 90)
                    send_request(CMD_FREE, RUN_W'($urandom),
                                 BLK_W'($urandom_range(0, ledger.total - 1)));
                else
                    send_request(CMD_FREE, RUN_W'($urandom), BLK_W'($urandom));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests and %0d results over %0d block-count writes",
                 ledger.requests, ledger.reports, settings);
        $display("statuses seen: ok %0d, no_space %0d, range %0d, already free %0d",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_NO_SPACE],
                 ledger.status_seen[ST_RANGE], ledger.status_seen[ST_ALREADY_FREE]);
        if (ledger.errors == 0 && ledger.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/bba_pkg.sv
rtl/bba_ifs.sv
rtl/bba_cell.sv
rtl/bba_bitmap.sv
rtl/bitmap_block_allocator.sv
tb/tb.sv
